@@ hdl/pdll_pkg.sv @@
// Package for the pooled doubly linked list: constants, command codes and payload types.
`timescale 1ns / 1ps
package pdll_pkg;
  localparam int unsigned CapacityDefault   = 128;
  localparam int unsigned ValueWidthDefault = 32;

  localparam logic [2:0] CMD_APPEND  = 3'd0;
  localparam logic [2:0] CMD_PREPEND = 3'd1;
  localparam logic [2:0] CMD_POP     = 3'd2;
  localparam logic [2:0] CMD_PEEK    = 3'd3;
  localparam logic [2:0] CMD_REMOVE  = 3'd4;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] head_x;
    logic signed [31:0] head_y;
    logic [7:0]         entry_total;
  } rsp_t;
endpackage

@@ hdl/pooled_doubly_linked_list.sv @@
// Top level of the pooled doubly linked list of coordinate pairs.
`timescale 1ns / 1ps
// The list holds up to CAPACITY (x, y) pairs in one pool memory, one entry per
// slot carrying the pair and its next and prev links. Each request is one
// command and yields one response. Append and prepend scan the occupancy bits
// one slot a cycle for the lowest free slot. Remove walks the list from the
// head one memory read per cycle; each walk step waits on the registered
// memory read before the next link is known. The occupancy bits are flip-flops
// cleared by reset, so no clearing pass is needed. A new request is taken
// only after the response register has been freed by the consumer.
// The entry_total field reports the count truncated to eight bits.
module pooled_doubly_linked_list
  import pdll_pkg::*;
#(
  parameter int unsigned CAPACITY    = CapacityDefault,
  parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Entry layout: {x, y, next, prev}.
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] x;
    logic [VALUE_WIDTH-1:0] y;
    logic [AW-1:0]          nxt;
    logic [AW-1:0]          prv;
  } ent_t;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;  // search for lowest free slot
  localparam logic [3:0] S_RD    = 4'd2;  // read of the neighbor entry issued
  localparam logic [3:0] S_INS   = 4'd3;  // write updated neighbor entry
  localparam logic [3:0] S_INS2  = 4'd4;
  localparam logic [3:0] S_WALK  = 4'd5;  // data of walked entry available
  localparam logic [3:0] S_UNL   = 4'd6;  // entry to unlink is in hand
  localparam logic [3:0] S_RDP   = 4'd7;  // prev neighbor read returns
  localparam logic [3:0] S_RDN   = 4'd8;  // next neighbor read returns
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_PEEK  = 4'd10;

  ent_t mem [CAPACITY];
  ent_t rdata_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  ent_t          wdata;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  logic [CAPACITY-1:0] used_q, used_d;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [3:0]    st_q, st_d;
  req_t          req_q, req_d;
  logic [AW-1:0] ptr_q, ptr_d;   // free slot or walked entry
  logic [CW-1:0] k_q, k_d;       // walk steps left
  ent_t          cur_q, cur_d;   // entry being unlinked
  logic          rv_q, rv_d;
  rsp_t          rsp_q, rsp_d;

  logic [VALUE_WIDTH-1:0] xv, yv;
  assign xv = req_q.x_value[VALUE_WIDTH-1:0];
  assign yv = req_q.y_value[VALUE_WIDTH-1:0];

  assign req_ready_o = (st_q == S_IDLE) && !rv_q;
  assign rsp_valid_o = rv_q;
  assign rsp_o       = rsp_q;

  function automatic logic [31:0] sext(input logic [VALUE_WIDTH-1:0] v);
    return 32'(signed'(v));
  endfunction

  always_comb begin
    st_d = st_q; used_d = used_q; head_d = head_q; tail_d = tail_q;
    cnt_d = cnt_q; req_d = req_q; ptr_d = ptr_q; k_d = k_q; cur_d = cur_q;
    rv_d = rv_q; rsp_d = rsp_q;
    rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_addr = '0; wdata = rdata_q;
    if (rv_q && rsp_ready_i) begin
      rv_d = 1'b0;
    end
    case (st_q)
      S_IDLE: begin
        if (req_valid_i && req_ready_o) begin
          req_d = req_i;
          rsp_d = '0;
          ptr_d = '0;
          k_d   = cnt_q;
          case (req_i.command)
            CMD_APPEND, CMD_PREPEND: begin
              st_d = (cnt_q < CW'(CAPACITY)) ? S_SCAN : S_DONE;
            end
            CMD_POP, CMD_PEEK, CMD_REMOVE: begin
              if (cnt_q == '0) begin
                st_d = S_DONE;
              end else begin
                rd_en = 1'b1; rd_addr = head_q; ptr_d = head_q;
                st_d = (req_i.command == CMD_PEEK) ? S_PEEK :
                       (req_i.command == CMD_POP) ? S_UNL : S_WALK;
              end
            end
            default: st_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (!used_q[ptr_q]) begin
          if (cnt_q == '0) begin
            wr_en = 1'b1; wr_addr = ptr_q;
            wdata = '{x: xv, y: yv, nxt: ptr_q, prv: ptr_q};
            head_d = ptr_q; tail_d = ptr_q;
            st_d = S_INS2;
          end else begin
            rd_en = 1'b1;
            rd_addr = (req_q.command == CMD_APPEND) ? tail_q : head_q;
            st_d = S_RD;
          end
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      S_RD: st_d = S_INS;
      S_INS: begin
        wr_en = 1'b1;
        wdata = rdata_q;
        if (req_q.command == CMD_APPEND) begin
          wr_addr = tail_q; wdata.nxt = ptr_q;
        end else begin
          wr_addr = head_q; wdata.prv = ptr_q;
        end
        st_d = S_INS2;
      end
      S_INS2: begin
        if (cnt_q != '0) begin
          wr_en = 1'b1; wr_addr = ptr_q;
          if (req_q.command == CMD_APPEND) begin
            wdata = '{x: xv, y: yv, nxt: ptr_q, prv: tail_q};
            tail_d = ptr_q;
          end else begin
            wdata = '{x: xv, y: yv, nxt: head_q, prv: ptr_q};
            head_d = ptr_q;
          end
        end
        used_d[ptr_q] = 1'b1;
        cnt_d = cnt_q + CW'(1);
        rsp_d.ok = 1'b1;
        st_d = S_DONE;
      end
      S_PEEK: begin
        rsp_d.ok = 1'b1;
        rsp_d.head_x = sext(rdata_q.x);
        rsp_d.head_y = sext(rdata_q.y);
        st_d = S_DONE;
      end
      S_WALK: begin
        if (rdata_q.x == xv && rdata_q.y == yv) begin
          st_d = S_UNL;
        end else if (k_q == CW'(1)) begin
          st_d = S_DONE;
        end else begin
          k_d = k_q - CW'(1);
          rd_en = 1'b1; rd_addr = rdata_q.nxt; ptr_d = rdata_q.nxt;
        end
      end
      S_UNL: begin
        // rdata_q holds the entry at ptr_q.
        cur_d = rdata_q;
        used_d[ptr_q] = 1'b0;
        cnt_d = cnt_q - CW'(1);
        rsp_d.ok = 1'b1;
        if (cnt_q == CW'(1)) begin
          head_d = '0; tail_d = '0; st_d = S_DONE;
        end else if (ptr_q == head_q) begin
          head_d = rdata_q.nxt; st_d = S_DONE;
        end else if (ptr_q == tail_q) begin
          tail_d = rdata_q.prv; st_d = S_DONE;
        end else begin
          rd_en = 1'b1; rd_addr = rdata_q.prv; st_d = S_RDP;
        end
      end
      S_RDP: begin
        wr_en = 1'b1; wr_addr = cur_q.prv;
        wdata = rdata_q; wdata.nxt = cur_q.nxt;
        // The next neighbor differs from prev, so no forwarding is needed.
        rd_en = 1'b1; rd_addr = cur_q.nxt;
        st_d = S_RDN;
      end
      S_RDN: begin
        wr_en = 1'b1; wr_addr = cur_q.nxt;
        wdata = rdata_q; wdata.prv = cur_q.prv;
        st_d = S_DONE;
      end
      S_DONE: begin
        if (!rv_q) begin
          rsp_d.entry_total = 8'(cnt_q);
          rv_d = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; used_q <= '0; head_q <= '0; tail_q <= '0;
      cnt_q <= '0; rv_q <= 1'b0;
    end else begin
      st_q <= st_d; used_q <= used_d; head_q <= head_d; tail_q <= tail_d;
      cnt_q <= cnt_d; rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; ptr_q <= ptr_d; k_q <= k_d; cur_q <= cur_d; rsp_q <= rsp_d;
  end
endmodule

@@ hdl/pdll_checker.sv @@
// Port checker for the pooled doubly linked list, bound to the top level.
`timescale 1ns / 1ps
module pdll_checker
  import pdll_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_o,
  input logic rsp_valid_o,
  input logic rsp_ready_i,
  input rsp_t rsp_o
);
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !req_ready_o)
    else $error("request taken while a response waits");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o && !rsp_valid_o)
    else $error("ready after accept");
  a_peek_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.ok |-> rsp_o.head_x == 0 && rsp_o.head_y == 0)
    else $error("pair reported on failure");
endmodule

bind pooled_doubly_linked_list pdll_checker u_pdll_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .req_valid_i(req_valid_i),
  .req_ready_o(req_ready_o), .rsp_valid_o(rsp_valid_o),
  .rsp_ready_i(rsp_ready_i), .rsp_o(rsp_o)
);
